@@ rtl/core/kra_pkg.sv @@
// shared constants, codes and types of the keystone address generator
`default_nettype none
package kra_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int MAX_DIM     = 4096;
	localparam int FRAC_BITS   = 14;
	localparam int VAL_W       = 18;
	localparam int DIM_W       = 13;
	localparam int PIX_W       = 12;
	localparam int POS_W       = 10;
	localparam int TAB_W       = 2 * VAL_W;
	localparam int DIV_NW      = VAL_W + IDX_W;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_KNOT  = 2'd1,
		OP_BUILD = 2'd2,
		OP_MAP   = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_SCALE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_ROW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOT_SCALE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOT_ROW    = 3'd5;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIM_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	// zero acts as one, oversize clamps to the largest frame
	function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/kra_div.sv @@
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module kra_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kra_pkg::div_req_t req,
	output kra_pkg::div_rsp_t      rsp
);
	import kra_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIM_W-1:0]  rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIM_W:0]    sh;
	logic              fits;

	assign sh   = {rem_q, quo_q[DIV_NW-1]};
	assign fits = sh >= {1'b0, req.den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= CNT_W'(DIV_NW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// divisor is held steady by the caller while the unit runs
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DIM_W'(sh - {1'b0, req.den}) : DIM_W'(sh);
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/core/keystone_row_remap_addresses.sv @@
// keystone address generator: knot tables, interpolation build and pixel map
//
//  channel  handshake           payload
//  in       in_valid/in_stall   op knot_pos knot_scale knot_row out_row out_col
//  out      out_valid/out_stall src_row src_col in_range
//  cfg      cfg_valid/cfg_ready cfg_index cfg_data
//
// after reset every entry of the mark store is cleared before the first item is taken
// clear: sweeps the marks and loads entries 0 and 1023 from config; knot: written as it is taken
// build: each entry is read (S_BRD), checked (S_BCHK), stepped (S_BNXT), with S_BKNOT at a knot;
//   entries past the end knots are copied (S_BCOPY), inner ones take two shared 28 step divider passes
// map: index divided (S_MWAIT), entry read (S_MRD), result set (S_MFIN); outside the frame only S_MFIN
// a map result waits in the output register; the next map holds in its last step until it leaves
`default_nettype none
module keystone_row_remap_addresses (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      op,
	input  wire logic [kra_pkg::POS_W-1:0]       knot_pos,
	input  wire logic [kra_pkg::VAL_W-1:0]       knot_scale,
	input  wire logic [kra_pkg::VAL_W-1:0]       knot_row,
	input  wire logic [kra_pkg::PIX_W-1:0]       out_row,
	input  wire logic [kra_pkg::PIX_W-1:0]       out_col,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [kra_pkg::PIX_W-1:0]            src_row,
	output logic [kra_pkg::PIX_W-1:0]            src_col,
	output logic                                 in_range,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [kra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kra_pkg::VAL_W-1:0]       cfg_data
);
	import kra_pkg::*;

	localparam int CNT_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);
	localparam int NJ_W = VAL_W + DIM_W;
	localparam int PR_W = PIX_W + 3 + VAL_W + 1;
	localparam int T_W  = PR_W + 2;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_CLR, S_BRD, S_BCHK, S_BCOPY, S_BKNOT, S_BNXT,
		S_BMUL, S_BSUM, S_BWAIT, S_MWAIT, S_MRD, S_MFIN
	} state_t;

	state_t state_q;

	// configuration
	logic [DIM_W-1:0] width_q, height_q;
	logic [VAL_W-1:0] top_scale_q, top_row_q, bot_scale_q, bot_row_q;
	logic [DIM_W-1:0] w_d, h_d;

	assign cfg_ready = 1'b1;
	assign w_d = dim_of(width_q);
	assign h_d = dim_of(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_W'(640);
			height_q    <= DIM_W'(480);
			top_scale_q <= VAL_W'(16384);
			top_row_q   <= '0;
			bot_scale_q <= VAL_W'(16384);
			bot_row_q   <= VAL_W'(16384);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:     width_q     <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    height_q    <= cfg_data[DIM_W-1:0];
				REG_TOP_SCALE: top_scale_q <= cfg_data;
				REG_TOP_ROW:   top_row_q   <= cfg_data;
				REG_BOT_SCALE: bot_scale_q <= cfg_data;
				REG_BOT_ROW:   bot_row_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stores: {scale, row} per entry, and the knot marks
	logic [TAB_W-1:0] tab_mem [TABLE_DEPTH];
	logic             mark_mem [TABLE_DEPTH];
	logic             tab_we, mark_we, mark_wd;
	logic [IDX_W-1:0] tab_wa, mark_wa, rd_a;
	logic [TAB_W-1:0] tab_wd, tab_rd_q;
	logic             mark_rd_q;

	always_ff @(posedge clk) begin
		if (tab_we)
			tab_mem[tab_wa] <= tab_wd;
		tab_rd_q <= tab_mem[rd_a];
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[mark_wa] <= mark_wd;
		mark_rd_q <= mark_mem[rd_a];
	end

	// divider shared by map index and interpolation
	div_req_t div_req;
	div_rsp_t div_rsp;

	kra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// working registers
	logic [CNT_W-1:0]  i_q, k_q, end_q;
	logic [IDX_W-1:0]  p_q, n_q;
	logic              have_prev_q, tail_q, sel_q, ok_q;
	logic [TAB_W-1:0]  a_q, b_q, cp_q;
	logic [VAL_W-1:0]  res_sc_q;
	logic [DIV_NW-1:0] m1_s, m2_s;
	logic [PIX_W-1:0]  col_q;
	logic [NJ_W-1:0]   nj_s;
	logic signed [PR_W-1:0] prod_s;
	logic              out_valid_q, in_range_q;
	logic [PIX_W-1:0]  src_row_q, src_col_q;

	logic              acc, frame_ok;
	logic [POS_W+IDX_W-1:0] kidx_w;
	logic [IDX_W-1:0]  kidx;
	logic [IDX_W-1:0]  k_i;
	logic [VAL_W-1:0]  a_v, b_v;
	logic [IDX_W-1:0]  n_k, k_p;
	logic signed [PIX_W+2:0] d2;
	logic signed [T_W-1:0]   t;
	logic [NJ_W-FRAC_BITS-1:0] nj;
	logic [T_W-FRAC_BITS-3:0]  pix;
	logic              row_ok, col_pos_ok, col_neg_ok;

	assign in_stall = (state_q != S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign frame_ok = ({1'b0, out_row} < h_d) && ({1'b0, out_col} < w_d);
	assign kidx_w   = ({knot_pos, IDX_W'(0)} >> POS_W);
	assign kidx     = (kidx_w > (POS_W+IDX_W)'(LAST)) ? LAST : kidx_w[IDX_W-1:0];
	assign k_i      = k_q[IDX_W-1:0];
	assign a_v      = sel_q ? a_q[VAL_W-1:0] : a_q[TAB_W-1:VAL_W];
	assign b_v      = sel_q ? b_q[VAL_W-1:0] : b_q[TAB_W-1:VAL_W];
	assign n_k      = n_q - k_i;
	assign k_p      = k_i - p_q;
	assign rd_a     = (state_q == S_MWAIT) ? div_rsp.quo[IDX_W-1:0] : i_q[IDX_W-1:0];

	// map arithmetic on the registered products
	assign d2  = $signed({2'b00, col_q, 1'b0}) - $signed({2'b00, w_d});
	assign t   = $signed({{(T_W-PR_W){prod_s[PR_W-1]}}, prod_s})
	           + $signed({{(T_W-DIM_W-FRAC_BITS){1'b0}}, w_d, FRAC_BITS'(0)});
	assign nj  = nj_s[NJ_W-1:FRAC_BITS];
	assign pix = t[T_W-2:FRAC_BITS+1];
	assign row_ok     = nj < (NJ_W-FRAC_BITS)'(h_d);
	assign col_pos_ok = !t[T_W-1] && (pix < (T_W-FRAC_BITS-2)'(w_d));
	// a target just below zero still lands on column zero
	assign col_neg_ok = t[T_W-1] && (t > -($signed(T_W'(1)) <<< (FRAC_BITS + 1)));

	always_comb begin
		tab_we  = 1'b0;
		tab_wa  = k_i;
		tab_wd  = cp_q;
		mark_we = 1'b0;
		mark_wa = k_i;
		mark_wd = 1'b0;
		div_req = '{start: 1'b0, num: m1_s + m2_s, den: DIM_W'(n_q - p_q)};
		unique case (state_q)
			S_INIT: mark_we = 1'b1;
			S_CLR: begin
				mark_we = 1'b1;
				mark_wd = (k_i == '0) || (k_i == LAST);
				if (k_i == '0) begin
					tab_we = 1'b1;
					tab_wd = {top_scale_q, top_row_q};
				end else if (k_i == LAST) begin
					tab_we = 1'b1;
					tab_wd = {bot_scale_q, bot_row_q};
				end
			end
			S_IDLE: begin
				if (acc && op == OP_KNOT) begin
					tab_we  = 1'b1;
					tab_wa  = kidx;
					tab_wd  = {knot_scale, knot_row};
					mark_we = 1'b1;
					mark_wa = kidx;
					mark_wd = 1'b1;
				end
				if (acc && op == OP_MAP && frame_ok) begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'({out_row, IDX_W'(0)});
					div_req.den   = h_d;
				end
			end
			S_BCOPY: tab_we = 1'b1;
			S_BSUM:  div_req.start = 1'b1;
			S_BWAIT: begin
				if (div_rsp.done && sel_q) begin
					tab_we = 1'b1;
					tab_wd = {res_sc_q, div_rsp.quo[VAL_W-1:0]};
				end
			end
			S_MWAIT: div_req.den = h_d;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			k_q         <= '0;
			i_q         <= '0;
			end_q       <= '0;
			have_prev_q <= 1'b0;
			tail_q      <= 1'b0;
			sel_q       <= 1'b0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_MFIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT, S_CLR: begin
					k_q <= k_q + CNT_W'(1);
					if (k_i == LAST)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (acc) begin
						unique case (op)
							OP_CLEAR: begin
								k_q     <= '0;
								state_q <= S_CLR;
							end
							OP_BUILD: begin
								i_q         <= '0;
								have_prev_q <= 1'b0;
								state_q     <= S_BRD;
							end
							OP_MAP: begin
								col_q   <= out_col;
								ok_q    <= frame_ok;
								state_q <= frame_ok ? S_MWAIT : S_MFIN;
							end
							default: ;
						endcase
					end
				end
				S_BRD: state_q <= S_BCHK;
				S_BCHK: begin
					if (mark_rd_q) begin
						b_q <= tab_rd_q;
						n_q <= i_q[IDX_W-1:0];
						if (!have_prev_q && i_q != '0) begin
							cp_q    <= tab_rd_q;
							k_q     <= '0;
							end_q   <= i_q;
							tail_q  <= 1'b0;
							state_q <= S_BCOPY;
						end else if (have_prev_q && i_q != CNT_W'(p_q) + CNT_W'(1)) begin
							k_q     <= CNT_W'(p_q) + CNT_W'(1);
							sel_q   <= 1'b0;
							state_q <= S_BMUL;
						end else begin
							state_q <= S_BKNOT;
						end
					end else begin
						state_q <= S_BNXT;
					end
				end
				S_BCOPY: begin
					k_q <= k_q + CNT_W'(1);
					if (k_q + CNT_W'(1) == end_q)
						state_q <= tail_q ? S_IDLE : S_BKNOT;
				end
				S_BKNOT: begin
					p_q         <= n_q;
					a_q         <= b_q;
					have_prev_q <= 1'b1;
					state_q     <= S_BNXT;
				end
				S_BNXT: begin
					if (i_q == CNT_W'(LAST)) begin
						if (have_prev_q && p_q != LAST) begin
							cp_q    <= a_q;
							k_q     <= CNT_W'(p_q) + CNT_W'(1);
							end_q   <= CNT_W'(TABLE_DEPTH);
							tail_q  <= 1'b1;
							state_q <= S_BCOPY;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_BRD;
					end
				end
				S_BMUL: begin
					m1_s    <= DIV_NW'(a_v * n_k);
					m2_s    <= DIV_NW'(b_v * k_p);
					state_q <= S_BSUM;
				end
				S_BSUM: state_q <= S_BWAIT;
				S_BWAIT: begin
					if (div_rsp.done) begin
						if (!sel_q) begin
							res_sc_q <= div_rsp.quo[VAL_W-1:0];
							sel_q    <= 1'b1;
							state_q  <= S_BMUL;
						end else begin
							sel_q <= 1'b0;
							k_q   <= k_q + CNT_W'(1);
							state_q <= (k_i + IDX_W'(1) == n_q) ? S_BKNOT : S_BMUL;
						end
					end
				end
				S_MWAIT: begin
					if (div_rsp.done)
						state_q <= S_MRD;
				end
				S_MRD: begin
					nj_s    <= NJ_W'(tab_rd_q[VAL_W-1:0] * h_d);
					prod_s  <= PR_W'(d2 * $signed({1'b0, tab_rd_q[TAB_W-1:VAL_W]}));
					state_q <= S_MFIN;
				end
				S_MFIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (ok_q && row_ok && (col_pos_ok || col_neg_ok)) begin
							in_range_q <= 1'b1;
							src_row_q  <= nj[PIX_W-1:0];
							src_col_q  <= col_pos_ok ? pix[PIX_W-1:0] : '0;
						end else begin
							in_range_q <= 1'b0;
							src_row_q  <= '0;
							src_col_q  <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign src_row   = src_row_q;
	assign src_col   = src_col_q;
	assign in_range  = in_range_q;

	// a result only appears from the final map step
	a_out_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_MFIN))
		else $error("result raised outside map completion");

	// idle table writes come only from an accepted knot
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(tab_we && state_q == S_IDLE) |-> (acc && op == OP_KNOT))
		else $error("table written while idle without a knot");

	// the divider is never restarted while a caller waits on it
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (state_q == S_IDLE || state_q == S_BSUM))
		else $error("divider started from an unexpected step");

	// interpolation never writes a marked end of the segment
	a_lerp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BWAIT && tab_we) |-> (k_i != n_q && k_i != p_q))
		else $error("interpolation wrote a knot entry");

endmodule
`default_nettype wire

@@ tb/sv/keystone_map_checker.sv @@
// checker for the keystone address generator: tracks the tables, predicts map beats, compares
module keystone_map_checker
	import kra_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [1:0]           op,
	input  wire logic [POS_W-1:0]     knot_pos,
	input  wire logic [VAL_W-1:0]     knot_scale,
	input  wire logic [VAL_W-1:0]     knot_row,
	input  wire logic [PIX_W-1:0]     out_row,
	input  wire logic [PIX_W-1:0]     out_col,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic [PIX_W-1:0]     src_row,
	input  wire logic [PIX_W-1:0]     src_col,
	input  wire logic                 in_range,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [VAL_W-1:0]     cfg_data,
	output int                        errors,
	output int                        pending,
	output int                        maps_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] srow;
		logic [PIX_W-1:0] scol;
		logic             ok;
	} src_addr_t;

	logic [DIM_W-1:0] width_reg, height_reg;
	logic [VAL_W-1:0] top_scale_reg, top_row_reg, bot_scale_reg, bot_row_reg;
	logic [VAL_W-1:0] scale_tab [TABLE_DEPTH];
	logic [VAL_W-1:0] row_tab [TABLE_DEPTH];
	bit               marked [TABLE_DEPTH];
	src_addr_t        addr_q [$];

	function automatic logic [VAL_W-1:0] blend(longint a, longint b, int p, int n, int i);
		return VAL_W'((a * (n - i) + b * (i - p)) / (n - p));
	endfunction

	task automatic fill_tables();
		int prev;
		prev = -1;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (!marked[i]) continue;
			if (prev < 0) begin
				for (int k = 0; k < i; k++) begin
					scale_tab[k] = scale_tab[i];
					row_tab[k]   = row_tab[i];
				end
			end else begin
				for (int k = prev + 1; k < i; k++) begin
					scale_tab[k] = blend(scale_tab[prev], scale_tab[i], prev, i, k);
					row_tab[k]   = blend(row_tab[prev], row_tab[i], prev, i, k);
				end
			end
			prev = i;
		end
		if (prev >= 0)
			for (int k = prev + 1; k < TABLE_DEPTH; k++) begin
				scale_tab[k] = scale_tab[prev];
				row_tab[k]   = row_tab[prev];
			end
	endtask

	function automatic src_addr_t remap_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
		src_addr_t a;
		longint w, h, idx, nj, t;
		a = '0;
		w = dim_of(width_reg);
		h = dim_of(height_reg);
		if (r < h && c < w) begin
			idx = (longint'(r) * TABLE_DEPTH) / h;
			if (idx > TABLE_DEPTH - 1) idx = TABLE_DEPTH - 1;
			nj = (longint'(row_tab[idx]) * h) >>> FRAC_BITS;
			if (nj < h) begin
				t = (2 * longint'(c) - w) * longint'(scale_tab[idx]) + w * (64'sd1 <<< FRAC_BITS);
				if (t < 0) begin
					// small negative target truncates to column zero
					if (-t < (64'sd1 <<< (FRAC_BITS + 1))) begin
						a.srow = PIX_W'(nj);
						a.ok   = 1'b1;
					end
				end else if ((t >>> (FRAC_BITS + 1)) < w) begin
					a.srow = PIX_W'(nj);
					a.scol = PIX_W'(t >>> (FRAC_BITS + 1));
					a.ok   = 1'b1;
				end
			end
		end
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		src_addr_t e;
		if (!arst_n) begin
			width_reg     <= DIM_W'(640);
			height_reg    <= DIM_W'(480);
			top_scale_reg <= VAL_W'(16384);
			top_row_reg   <= '0;
			bot_scale_reg <= VAL_W'(16384);
			bot_row_reg   <= VAL_W'(16384);
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				scale_tab[i] = '0;
				row_tab[i]   = '0;
				marked[i]    = 1'b0;
			end
			addr_q.delete();
			errors    <= 0;
			pending   <= 0;
			maps_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:     width_reg     <= cfg_data[DIM_W-1:0];
					REG_HEIGHT:    height_reg    <= cfg_data[DIM_W-1:0];
					REG_TOP_SCALE: top_scale_reg <= cfg_data;
					REG_TOP_ROW:   top_row_reg   <= cfg_data;
					REG_BOT_SCALE: bot_scale_reg <= cfg_data;
					REG_BOT_ROW:   bot_row_reg   <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				maps_seen <= maps_seen + 1;
				if (addr_q.size() == 0) begin
					$display("%0t: unexpected result beat src_row %0d src_col %0d in_range %0d",
						$time, src_row, src_col, in_range);
					errors <= errors + 1;
				end else begin
					e = addr_q.pop_front();
					if (e.srow !== src_row || e.scol !== src_col || e.ok !== in_range) begin
						$display("%0t: mismatch expected row %0d col %0d ok %0d, got row %0d col %0d ok %0d",
							$time, e.srow, e.scol, e.ok, src_row, src_col, in_range);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (op_t'(op))
					OP_CLEAR: begin
						for (int i = 0; i < TABLE_DEPTH; i++) marked[i] = 1'b0;
						scale_tab[0] = top_scale_reg;
						row_tab[0]   = top_row_reg;
						scale_tab[TABLE_DEPTH-1] = bot_scale_reg;
						row_tab[TABLE_DEPTH-1]   = bot_row_reg;
						marked[0] = 1'b1;
						marked[TABLE_DEPTH-1] = 1'b1;
					end
					OP_KNOT: begin
						scale_tab[knot_pos] = knot_scale;
						row_tab[knot_pos]   = knot_row;
						marked[knot_pos]    = 1'b1;
					end
					OP_BUILD: fill_tables();
					OP_MAP:   addr_q.push_back(remap_pixel(out_row, out_col));
				endcase
			end
			pending <= addr_q.size();
		end
	end
endmodule

@@ tb/sv/testbench.sv @@
// top of the keystone address generator testbench: clock, reset, stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import kra_pkg::*;

	localparam int QUIET_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           op = OP_MAP;
	logic [POS_W-1:0]     knot_pos = '0;
	logic [VAL_W-1:0]     knot_scale = '0;
	logic [VAL_W-1:0]     knot_row = '0;
	logic [PIX_W-1:0]     out_row = '0;
	logic [PIX_W-1:0]     out_col = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     src_row, src_col;
	logic                 in_range;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0]     cfg_data = '0;
	int                   errors, pending, maps_seen;
	int                   quiet_cycles = 0;
	int                   stall_left = 0;
	int                   items_sent = 0;
	int                   builds_sent = 0;
	bit                   calm = 1'b0;
	int                   w_eff, h_eff;

	always #6 clk = ~clk;

	keystone_row_remap_addresses uut (.*);
	keystone_map_checker chk (.*);

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic put_item(logic [1:0] o, logic [POS_W-1:0] p, logic [VAL_W-1:0] s,
		logic [VAL_W-1:0] r, logic [PIX_W-1:0] orow, logic [PIX_W-1:0] ocol);
		in_valid   <= 1'b1;
		op         <= o;
		knot_pos   <= p;
		knot_scale <= s;
		knot_row   <= r;
		out_row    <= orow;
		out_col    <= ocol;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (o == OP_BUILD) builds_sent++;
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic put_map(logic [PIX_W-1:0] r, logic [PIX_W-1:0] c);
		put_item(OP_MAP, POS_W'($urandom), VAL_W'($urandom), VAL_W'($urandom), r, c);
	endtask

	task automatic put_knot(logic [POS_W-1:0] p, logic [VAL_W-1:0] s, logic [VAL_W-1:0] r);
		put_item(OP_KNOT, p, s, r, PIX_W'($urandom), PIX_W'($urandom));
	endtask

	task automatic put_cmd(logic [1:0] o);
		put_item(o, POS_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
			PIX_W'($urandom), PIX_W'($urandom));
	endtask

	// a map beat cannot leave before earlier work is done, so its return means idle
	task automatic drain();
		put_map('0, '0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] pick_val();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return VAL_W'(16384);
			3: return VAL_W'($urandom_range(8192, 32768));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 7))
			0: return 1;
			1: return 4096;
			2: return 0;
			3: return 8191;
			4: return $urandom_range(1, 16);
			default: return $urandom_range(1, 4096);
		endcase
	endfunction

	task automatic set_frame(int w, int h);
		write_reg(REG_WIDTH, VAL_W'(w));
		write_reg(REG_HEIGHT, VAL_W'(h));
		w_eff = (w == 0) ? 1 : (w > MAX_DIM ? MAX_DIM : w);
		h_eff = (h == 0) ? 1 : (h > MAX_DIM ? MAX_DIM : h);
	endtask

	task automatic random_map();
		if ($urandom_range(0, 9) == 0)
			put_map(PIX_W'($urandom), PIX_W'($urandom));
		else
			put_map(PIX_W'($urandom_range(0, h_eff - 1)), PIX_W'($urandom_range(0, w_eff - 1)));
	endtask

	initial begin
		w_eff = 640;
		h_eff = 480;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: build with no knots, defaults, end knots, corners
		put_cmd(OP_BUILD);
		put_cmd(OP_CLEAR);
		put_knot('0, VAL_W'(16385), '0);
		put_knot(POS_W'(512), '0, VAL_W'(8192));
		put_knot('1, '1, '1);
		put_cmd(OP_BUILD);
		put_map('0, '0);
		put_map('0, PIX_W'(639));
		put_map(PIX_W'(479), PIX_W'(639));
		put_map(PIX_W'(256), PIX_W'(320));
		put_map(PIX_W'(480), '0);
		put_map('0, PIX_W'(640));
		put_map('1, '1);
		put_cmd(OP_CLEAR);
		put_cmd(OP_BUILD);
		put_map(PIX_W'(240), '0);
		put_map(PIX_W'(479), PIX_W'(100));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			calm = (ph == 7);
			case (ph)
				0: set_frame(1, 1);
				1: set_frame(4096, 4096);
				2: set_frame(0, 8191);
				3: set_frame(8191, 0);
				default: set_frame(pick_dim(), pick_dim());
			endcase
			write_reg(REG_TOP_SCALE, pick_val());
			write_reg(REG_TOP_ROW, (ph == 1) ? '1 : pick_val());
			write_reg(REG_BOT_SCALE, pick_val());
			write_reg(REG_BOT_ROW, (ph == 1) ? '0 : pick_val());
			put_cmd(OP_CLEAR);
			repeat ($urandom_range(0, 6))
				put_knot(POS_W'($urandom), pick_val(), VAL_W'($urandom_range(0, 20000)));
			if ($urandom_range(0, 1)) put_knot($urandom_range(0, 1) ? '0 : '1, pick_val(), pick_val());
			put_cmd(OP_BUILD);
			repeat (230) begin
				case ($urandom_range(0, 19))
					0: put_knot(POS_W'($urandom), pick_val(), pick_val());
					1: if ($urandom_range(0, 3) == 0) put_cmd(OP_CLEAR);
					default: random_map();
				endcase
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("ran %0d items with %0d builds over 9 frame settings; %0d address beats returned",
			items_sent, builds_sent, maps_seen);
		if (errors == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
